/* rtl/alw_pkg.sv */
// shared types and constants for the arm logical alu with shifter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package alw_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int REG_COUNT  = 16;
   localparam int REG_BITS   = 4;
   localparam int AMT_BITS   = 6;

   localparam logic [REG_BITS-1:0] PC_INDEX = 4'd15;
   localparam logic [AMT_BITS-1:0] WORD_BITS = 6'd32;

   typedef enum logic [2:0] {
      OP_AND = 3'd0,
      OP_BIC = 3'd1,
      OP_EOR = 3'd2,
      OP_MVN = 3'd3,
      OP_ORN = 3'd4,
      OP_ORR = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      SH_LSL = 3'd0,
      SH_LSR = 3'd1,
      SH_ASR = 3'd2,
      SH_ROR = 3'd3,
      SH_RRX = 3'd4
   } shift_type;

   typedef logic [DATA_WIDTH-1:0] word_type;

   // stored condition flags; v is never changed by these instructions
   typedef struct packed {
      logic n;
      logic z;
      logic c;
   } flags_type;

   typedef struct packed {
      logic                en;
      logic [REG_BITS-1:0] addr;
      word_type            data;
   } reg_write_type;

   typedef struct packed {
      word_type  result_value;
      logic      reg_written;
      logic      unsupported;
      logic      flags_en;
      flags_type flags;
   } alu_out_type;

endpackage

/* rtl/alw_regfile.sv */
// 16 x 32 register file, two registered read ports, one write port
// write-to-read forwarding and per-entry valid bits so reset reads zero; uses alw_pkg
`timescale 1ns / 1ps

module alw_regfile (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [alw_pkg::REG_BITS-1:0]  ra_addr,
   input  logic [alw_pkg::REG_BITS-1:0]  rb_addr,
   input  alw_pkg::reg_write_type        wr,
   output alw_pkg::word_type             ra_data,
   output alw_pkg::word_type             rb_data
);
   import alw_pkg::*;

   word_type                 mem [REG_COUNT];
   logic [REG_COUNT-1:0]     valid_ff;
   logic [REG_COUNT-1:0]     valid_in;
   word_type                 ra_ff;
   word_type                 rb_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // a write at the same edge as the read is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && wr.addr == ra_addr) begin
            ra_ff <= wr.data;
         end else if (!valid_ff[ra_addr]) begin
            ra_ff <= '0;
         end else begin
            ra_ff <= mem[ra_addr];
         end
         if (wr.en && wr.addr == rb_addr) begin
            rb_ff <= wr.data;
         end else if (!valid_ff[rb_addr]) begin
            rb_ff <= '0;
         end else begin
            rb_ff <= mem[rb_addr];
         end
      end
   end

   assign ra_data = ra_ff;
   assign rb_data = rb_ff;

endmodule

/* rtl/alw_shifter.sv */
// barrel shifter with carry out: lsl, lsr, asr, ror and rrx
// purely combinational; uses alw_pkg
`timescale 1ns / 1ps

module alw_shifter (
   input  alw_pkg::word_type             value,
   input  logic [2:0]                    kind,
   input  logic [alw_pkg::AMT_BITS-1:0]  amount,
   input  logic                          carry_in,
   output alw_pkg::word_type             shifted,
   output logic                          carry_result
);
   import alw_pkg::*;

   logic                  sign;
   logic [4:0]            lsl_idx;
   logic [4:0]            rsh_idx;
   logic [4:0]            rot;
   logic [2*DATA_WIDTH-1:0] doubled;
   word_type              rotated;

   always_comb begin
      sign    = value[DATA_WIDTH-1];
      lsl_idx = 5'(WORD_BITS - amount);
      rsh_idx = 5'(amount - 6'd1);
      rot     = amount[4:0];
      doubled = {value, value} >> rot;
      rotated = doubled[DATA_WIDTH-1:0];

      shifted      = value;
      carry_result = carry_in;
      if (kind == SH_RRX) begin
         shifted      = {carry_in, value[DATA_WIDTH-1:1]};
         carry_result = value[0];
      end else if (amount != '0) begin
         case (kind)
            SH_LSL: begin
               shifted = value << amount;
               if (amount < WORD_BITS) begin
                  carry_result = value[lsl_idx];
               end else if (amount == WORD_BITS) begin
                  carry_result = value[0];
               end else begin
                  carry_result = 1'b0;
               end
            end
            SH_LSR: begin
               shifted = value >> amount;
               // by exactly 32 the index lands on bit 31
               carry_result = (amount <= WORD_BITS) ? value[rsh_idx] : 1'b0;
            end
            SH_ASR: begin
               if (amount < WORD_BITS) begin
                  shifted      = word_type'($signed(value) >>> amount);
                  carry_result = value[rsh_idx];
               end else begin
                  shifted      = {DATA_WIDTH{sign}};
                  carry_result = sign;
               end
            end
            SH_ROR: begin
               shifted      = rotated;
               carry_result = rotated[DATA_WIDTH-1];
            end
            default: begin
               shifted      = value;
               carry_result = carry_in;
            end
         endcase
      end
   end

endmodule

/* rtl/alw_logic_unit.sv */
// logical operation, pc-write check and next flag values
// purely combinational; uses alw_pkg
`timescale 1ns / 1ps

module alw_logic_unit (
   input  logic [2:0]                    operation,
   input  logic                          use_immediate,
   input  logic [alw_pkg::REG_BITS-1:0]  dest_reg,
   input  logic                          set_flags,
   input  alw_pkg::word_type             first_value,
   input  alw_pkg::word_type             second_value,
   input  logic                          second_carry,
   input  alw_pkg::flags_type            flags,
   output alw_pkg::alu_out_type          alu_out
);
   import alw_pkg::*;

   word_type raw;
   logic     known_op;
   logic     pc_write;

   always_comb begin
      known_op = 1'b1;
      case (operation)
         OP_AND:  raw = first_value & second_value;
         OP_BIC:  raw = first_value & ~second_value;
         OP_EOR:  raw = first_value ^ second_value;
         OP_MVN:  raw = ~second_value;
         OP_ORN:  raw = first_value | ~second_value;
         OP_ORR:  raw = first_value | second_value;
         default: begin
            raw      = '0;
            known_op = 1'b0;
         end
      endcase

      pc_write = (operation == OP_AND) && use_immediate && (dest_reg == PC_INDEX);

      alu_out.unsupported  = pc_write;
      alu_out.reg_written  = known_op && !pc_write;
      alu_out.result_value = alu_out.reg_written ? raw : '0;
      alu_out.flags_en     = alu_out.reg_written && set_flags;
      alu_out.flags        = flags;
      if (alu_out.flags_en) begin
         alu_out.flags.n = raw[DATA_WIDTH-1];
         alu_out.flags.z = (raw == '0);
         alu_out.flags.c = second_carry;
      end
   end

endmodule

/* rtl/arm_logical_alu_with_shifter.sv */
// Executes one ARM logical instruction (and, bic, eor, mvn, orn, orr) per transfer, with an
// immediate or a shifted register as second operand, and keeps the 16-entry register file and
// the n, z, c flags. The register file is read at the input transfer edge into registered read
// ports, next to the input register; the instruction held there then does shift, logic and flags
// and, at the edge where it advances, writes the register file, flags and result register
// together, and the result register offers the result on the output. A new instruction is taken
// every cycle unless the pipe stalls; a result written at one edge is forwarded to the read of
// the instruction accepted at that edge, so dependent instructions run back to back. The pipe
// stalls only while the result register holds a result and rsp_tready is low.
// Depends on alw_pkg, alw_regfile, alw_shifter and alw_logic_unit.
`timescale 1ns / 1ps

module arm_logical_alu_with_shifter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // dest_reg[3:0], first_reg[7:4], second_reg[11:8], immediate[43:12],
   // immediate_carry[44], shift_amount[50:45], zero fill[55:51]
   input  logic [55:0] req_tdata,
   // operation[2:0], use_immediate[3], set_flags[4], shift_kind[7:5]
   input  logic [7:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_value[31:0], flag_negative[32], flag_zero[33], flag_carry[34], zero fill[39:35]
   output logic [39:0] rsp_tdata,
   // reg_written[0], unsupported[1]
   output logic [1:0]  rsp_tuser
);
   import alw_pkg::*;

   logic                in_valid_ff, in_valid_in;
   logic                out_valid_ff, out_valid_in;
   logic                advance;
   logic                req_xfer;

   logic [2:0]          op_ff;
   logic                use_imm_ff;
   logic [REG_BITS-1:0] dest_ff;
   word_type            imm_ff;
   logic                imm_c_ff;
   logic                setf_ff;
   logic [2:0]          kind_ff;
   logic [AMT_BITS-1:0] amt_ff;

   flags_type           flags_ff, flags_in;
   word_type            first_value, rm_value;
   word_type            shifted, second_value;
   logic                shift_carry, second_carry;
   alu_out_type         alu_out;
   reg_write_type       wr;
   logic                do_exec;

   word_type            res_ff;
   logic                written_ff, unsup_ff;
   flags_type           res_flags_ff;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;
   assign do_exec    = in_valid_ff && advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff      <= req_tuser[2:0];
         use_imm_ff <= req_tuser[3];
         setf_ff    <= req_tuser[4];
         kind_ff    <= req_tuser[7:5];
         dest_ff    <= req_tdata[3:0];
         imm_ff     <= req_tdata[43:12];
         imm_c_ff   <= req_tdata[44];
         amt_ff     <= req_tdata[50:45];
      end
   end

   alw_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_xfer),
      .ra_addr (req_tdata[7:4]),
      .rb_addr (req_tdata[11:8]),
      .wr      (wr),
      .ra_data (first_value),
      .rb_data (rm_value)
   );

   alw_shifter u_shifter (
      .value        (rm_value),
      .kind         (kind_ff),
      .amount       (amt_ff),
      .carry_in     (flags_ff.c),
      .shifted      (shifted),
      .carry_result (shift_carry)
   );

   assign second_value = use_imm_ff ? imm_ff : shifted;
   assign second_carry = use_imm_ff ? imm_c_ff : shift_carry;

   alw_logic_unit u_logic (
      .operation     (op_ff),
      .use_immediate (use_imm_ff),
      .dest_reg      (dest_ff),
      .set_flags     (setf_ff),
      .first_value   (first_value),
      .second_value  (second_value),
      .second_carry  (second_carry),
      .flags         (flags_ff),
      .alu_out       (alu_out)
   );

   always_comb begin
      wr.en    = do_exec && alu_out.reg_written;
      wr.addr  = dest_ff;
      wr.data  = alu_out.result_value;
      flags_in = (do_exec && alu_out.flags_en) ? alu_out.flags : flags_ff;
   end

   always_ff @(posedge clock) begin
      if (do_exec) begin
         res_ff       <= alu_out.result_value;
         written_ff   <= alu_out.reg_written;
         unsup_ff     <= alu_out.unsupported;
         res_flags_ff <= alu_out.flags;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, res_flags_ff.c, res_flags_ff.z, res_flags_ff.n, res_ff};
   assign rsp_tuser  = {unsup_ff, written_ff};

endmodule
